// ----- rtl/swsb_pkg.sv -----
// Package for the sliding window sum and bit count block.
// Holds shared widths, command and register codes and the store write request type.
// No dependencies.
package swsb_pkg;

	localparam int STORE_DEPTH_DEF = 256;
	localparam int SAMPLE_W        = 32;
	localparam int SUM_W           = 40;
	localparam int COUNTS_W        = 64;
	localparam int SIZE_W          = 8;
	localparam int NEFF_W          = 9;
	localparam int BYTE_W          = 8;
	localparam int CFG_IDX_W       = 1;

	// Input commands.
	localparam logic CMD_PUSH  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_MODE  = 1'd1;

	// Counting modes.
	localparam logic MODE_SUM  = 1'b0;
	localparam logic MODE_BITS = 1'b1;

	localparam logic [SIZE_W-1:0] WINDOW_SIZE_RST = 8'd8;

	// Write request from the update stage back into the sample store.
	typedef struct packed {
		logic                en;
		logic [SAMPLE_W-1:0] data;
	} store_wr_t;

endpackage

// ----- rtl/swsb_ring.sv -----
// Sample ring: the sample store memory, the write position and the fill flag.
// Reads the oldest entry on each accepted request and forwards a same-cycle write.
// Depends on swsb_pkg.
module swsb_ring #(
	parameter int STORE_DEPTH = swsb_pkg::STORE_DEPTH_DEF,
	parameter int AW          = $clog2(STORE_DEPTH)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic                           clear,
	input  logic [swsb_pkg::NEFF_W-1:0]    n_eff,
	input  swsb_pkg::store_wr_t            wr,
	output logic [swsb_pkg::SAMPLE_W-1:0]  old_s1
);
	import swsb_pkg::*;

	logic [SAMPLE_W-1:0] mem [STORE_DEPTH];
	logic [AW-1:0]       pos_q;
	logic                wrapped_q;
	logic [AW-1:0]       addr_s1;
	logic                live_s1;
	logic [SAMPLE_W-1:0] rdata_s1;
	logic [NEFF_W-1:0]   pos_inc;
	logic                pos_wrap;

	// Next ring position with wrap at the active window size.
	always_comb begin
		pos_inc  = NEFF_W'(pos_q) + NEFF_W'(1);
		pos_wrap = (pos_inc >= n_eff);
	end

	// Write position and fill flag; an entry is only read as written once the ring wrapped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			wrapped_q <= 1'b0;
		end else if (clear) begin
			pos_q     <= '0;
			wrapped_q <= 1'b0;
		end else if (accept) begin
			if (pos_wrap) begin
				pos_q     <= '0;
				wrapped_q <= 1'b1;
			end else begin
				pos_q <= pos_inc[AW-1:0];
			end
		end
	end

	// Store write-back from the update stage.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[addr_s1] <= wr.data;
		end
	end

	// Registered read of the oldest entry, with forwarding of a write to the same entry.
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= pos_q;
			if (wr.en && (addr_s1 == pos_q)) begin
				rdata_s1 <= wr.data;
			end else begin
				rdata_s1 <= mem[pos_q];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s1 <= 1'b0;
		end else if (accept) begin
			live_s1 <= wrapped_q;
		end
	end

	assign old_s1 = live_s1 ? rdata_s1 : '0;

endmodule

// ----- rtl/swsb_accum.sv -----
// Update stage and output register: running sum and per-bit counters.
// Produces the store write-back and the result request.
// Depends on swsb_pkg.
module swsb_accum (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic                           cfg_clear,
	input  logic                           command,
	input  logic [swsb_pkg::SAMPLE_W-1:0]  fresh,
	input  logic                           count_mode,
	input  logic [swsb_pkg::SAMPLE_W-1:0]  old_s1,
	output logic                           s1_free,
	output swsb_pkg::store_wr_t            wr,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [swsb_pkg::SUM_W-1:0]     window_sum,
	output logic [swsb_pkg::COUNTS_W-1:0]  bit_counts
);
	import swsb_pkg::*;

	logic                valid_s1;
	logic                cmd_s1;
	logic [SAMPLE_W-1:0] fresh_s1;
	logic                adv;
	logic [SUM_W-1:0]    sum_q;
	logic [COUNTS_W-1:0] counts_q;
	logic [SUM_W-1:0]    sum_nxt;
	logic [COUNTS_W-1:0] counts_nxt;
	logic                out_valid_q;

	assign adv     = valid_s1 && (!out_valid_q || !out_stall);
	assign s1_free = !valid_s1 || adv;

	// Stage one request registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= command;
			fresh_s1 <= fresh;
		end
	end

	// Remove the oldest sample and add the new one; a clear command zeroes both sums.
	always_comb begin
		sum_nxt    = sum_q;
		counts_nxt = counts_q;
		if (cmd_s1 == CMD_CLEAR) begin
			sum_nxt    = '0;
			counts_nxt = '0;
		end else if (count_mode == MODE_SUM) begin
			sum_nxt = sum_q - SUM_W'(signed'(old_s1)) + SUM_W'(signed'(fresh_s1));
		end else begin
			for (int i = 0; i < BYTE_W; i++) begin
				counts_nxt[i*BYTE_W +: BYTE_W] = counts_q[i*BYTE_W +: BYTE_W]
					- BYTE_W'(old_s1[i]) + BYTE_W'(fresh_s1[i]);
			end
		end
	end

	assign wr = '{en: adv && (cmd_s1 == CMD_PUSH), data: fresh_s1};

	// Running sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			counts_q <= '0;
		end else if (cfg_clear) begin
			sum_q    <= '0;
			counts_q <= '0;
		end else if (adv) begin
			sum_q    <= sum_nxt;
			counts_q <= counts_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			window_sum <= sum_nxt;
			bit_counts <= counts_nxt;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/sliding_window_sum_and_bit_counts.sv -----
// Sliding window sum and per-bit counts over a ring of the last N samples.
// A result passes through the stage-one request registers and the output
// register; output stalls delay it. Throughput: one request per cycle unless
// the output stalls; the registered store read overlaps the previous request's
// write-back, with forwarding when both hit one entry.
// Reset and any configuration write empty the window at once: no clearing pass.
// Depends on swsb_pkg, swsb_ring and swsb_accum.
module sliding_window_sum_and_bit_counts #(
	parameter int STORE_DEPTH = swsb_pkg::STORE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [swsb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swsb_pkg::SIZE_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            command,
	input  logic signed [swsb_pkg::SAMPLE_W-1:0] sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [swsb_pkg::SUM_W-1:0]    window_sum,
	output logic [swsb_pkg::COUNTS_W-1:0]   bit_counts
);
	import swsb_pkg::*;

	logic [SIZE_W-1:0]   window_size_q;
	logic                count_mode_q;
	logic [NEFF_W-1:0]   n_eff;
	logic                accept;
	logic                s1_free;
	logic                ring_clear;
	logic [SAMPLE_W-1:0] fresh;
	logic [SAMPLE_W-1:0] old_s1;
	logic [SUM_W-1:0]    sum_w;
	store_wr_t           wr;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RST;
			count_mode_q  <= MODE_SUM;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_WINDOW_SIZE: window_size_q <= cfg_data;
				REG_COUNT_MODE:  count_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Active window size: zero acts as one, large sizes saturate at the store depth.
	always_comb begin
		if (window_size_q == '0) begin
			n_eff = NEFF_W'(1);
		end else if (NEFF_W'(window_size_q) > NEFF_W'(STORE_DEPTH)) begin
			n_eff = NEFF_W'(STORE_DEPTH);
		end else begin
			n_eff = NEFF_W'(window_size_q);
		end
	end

	assign in_stall   = !s1_free;
	assign accept     = in_valid && s1_free;
	assign ring_clear = cfg_write || (accept && (command == CMD_CLEAR));

	// Bit mode keeps only the low byte of the sample.
	assign fresh = (count_mode_q == MODE_BITS) ? {{(SAMPLE_W-BYTE_W){1'b0}}, sample[BYTE_W-1:0]}
	                                           : sample;

	swsb_ring #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.clear  (ring_clear),
		.n_eff  (n_eff),
		.wr     (wr),
		.old_s1 (old_s1)
	);

	swsb_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.cfg_clear  (cfg_write),
		.command    (command),
		.fresh      (fresh),
		.count_mode (count_mode_q),
		.old_s1     (old_s1),
		.s1_free    (s1_free),
		.wr         (wr),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.window_sum (sum_w),
		.bit_counts (bit_counts)
	);

	assign window_sum = signed'(sum_w);

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for sliding_window_sum_and_bit_counts: directed table, then random phases.
// Results are checked against table values or a predictor of the sample ring, sum and bit counters.
// Depends on swsb_pkg and the RTL of the block.
module tb_top;
	import swsb_pkg::*;

	typedef struct packed {
		logic [SUM_W-1:0]    total;
		logic [COUNTS_W-1:0] counts;
	} window_result_t;

	typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic                 cmd;
		logic [SAMPLE_W-1:0]  smp;
		logic [CFG_IDX_W-1:0] idx;
		logic [SIZE_W-1:0]    data;
		logic                 typed;
		window_result_t       want;
	} stim_row_t;

	typedef enum logic [1:0] {FEED_MIXED, FEED_TOP, FEED_BOTTOM} feed_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0]    cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 command   = CMD_PUSH;
	logic [SAMPLE_W-1:0]  sample    = '0;
	logic                 out_stall = 1'b0;
	logic                 in_stall;
	logic                 out_valid;
	logic [SUM_W-1:0]     window_sum;
	logic [COUNTS_W-1:0]  bit_counts;

	// Predicted state of the block.
	logic [SAMPLE_W-1:0] ring_copy [STORE_DEPTH_DEF];
	logic [SIZE_W-1:0]   next_slot;
	logic [SIZE_W-1:0]   size_reg;
	logic                mode_reg;
	logic [SUM_W-1:0]    sum_acc;
	logic [COUNTS_W-1:0] bit_tally;

	window_result_t pending_results[$];
	int             errors = 0;

	sliding_window_sum_and_bit_counts uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.window_sum (window_sum),
		.bit_counts (bit_counts)
	);

	initial begin : clock_gen
		forever #1 clk = ~clk;
	end

	// Gap length: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 0;
		else if (r < 18)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic stim_row_t row_request(input logic cmd, input logic [SAMPLE_W-1:0] smp,
			input logic typed, input logic [SUM_W-1:0] total, input logic [COUNTS_W-1:0] counts);
		stim_row_t row;
		row = '0;
		row.kind = ROW_REQUEST;
		row.cmd = cmd;
		row.smp = smp;
		row.typed = typed;
		row.want.total = total;
		row.want.counts = counts;
		return row;
	endfunction

	function automatic stim_row_t row_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [SIZE_W-1:0] data);
		stim_row_t row;
		row = '0;
		row.kind = ROW_WRITE;
		row.idx = idx;
		row.data = data;
		return row;
	endfunction

	// Clearing empties the ring, both sums and the write slot.
	task automatic empty_window();
		for (int i = 0; i < STORE_DEPTH_DEF; i++)
			ring_copy[i] = '0;
		next_slot = '0;
		sum_acc = '0;
		bit_tally = '0;
	endtask

	// Applies one request to the predicted window and returns the sums after it.
	task automatic advance_window(input logic cmd, input logic [SAMPLE_W-1:0] smp,
			output window_result_t res);
		int                  n;
		int                  pos;
		logic [SAMPLE_W-1:0] old;
		logic [BYTE_W-1:0]   nb;
		logic [BYTE_W-1:0]   cnt;
		n = (size_reg == 0) ? 1 : int'(size_reg);
		if (cmd == CMD_CLEAR) begin
			empty_window();
		end else begin
			pos = next_slot;
			if (pos >= n)
				pos = 0;
			old = ring_copy[pos];
			if (mode_reg == MODE_SUM) begin
				sum_acc = sum_acc - {{(SUM_W-SAMPLE_W){old[SAMPLE_W-1]}}, old}
					+ {{(SUM_W-SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
				ring_copy[pos] = smp;
			end else begin
				// Only the low byte is kept; each counter tracks one bit position.
				nb = smp[BYTE_W-1:0];
				for (int i = 0; i < BYTE_W; i++) begin
					cnt = bit_tally[i*BYTE_W +: BYTE_W] - old[i] + nb[i];
					bit_tally[i*BYTE_W +: BYTE_W] = cnt;
				end
				ring_copy[pos] = {{(SAMPLE_W-BYTE_W){1'b0}}, nb};
			end
			pos++;
			if (pos >= n)
				pos = 0;
			next_slot = pos[SIZE_W-1:0];
		end
		res.total = sum_acc;
		res.counts = bit_tally;
	endtask

	// Stops new requests and waits until the block has delivered every result.
	task automatic await_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register writes happen only with the block idle; each one empties the window.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
		await_idle();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_WINDOW_SIZE)
			size_reg = data;
		else
			mode_reg = data[0];
		empty_window();
	endtask

	// Offers one request, holds it until accepted, then records the expected result.
	task automatic send_request(input logic cmd, input logic [SAMPLE_W-1:0] smp, input logic typed,
			input window_result_t want, input bit steady);
		int             gap;
		window_result_t res;
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		sample <= smp;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		advance_window(cmd, smp, res);
		pending_results.push_back(typed ? want : res);
	endtask

	// Output backpressure: free runs of random length, some long, between stalls.
	initial begin : stall_driver
		int free;
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			free = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
			repeat (free) @(posedge clk);
			hold = pick_gap();
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Each accepted result is compared with the oldest expectation.
	always @(posedge clk) begin : result_check
		window_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				$error("window_sum: no request pending, got %h", window_sum);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (window_sum !== want.total) begin
					$error("window_sum: expected %h, got %h", want.total, window_sum);
					errors++;
				end
				if (bit_counts !== want.counts) begin
					$error("bit_counts: expected %h, got %h", want.counts, bit_counts);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		stim_row_t           directed[$];
		logic [SIZE_W-1:0]   size_pick;
		logic                mode_pick;
		logic [6:0]          pad;
		logic [SAMPLE_W-1:0] smp;
		logic                cmd;
		feed_t               feed;
		bit                  steady;
		int                  done;
		int                  items;
		int                  phase;
		int                  r;

		empty_window();
		size_reg = WINDOW_SIZE_RST;
		mode_reg = MODE_SUM;

		// Directed table: window of eight after reset, sum mode.
		directed.push_back(row_request(CMD_PUSH, 32'h0000_0000, 1, 40'h00_0000_0000, 64'h0));
		directed.push_back(row_request(CMD_PUSH, 32'h7FFF_FFFF, 1, 40'h00_7FFF_FFFF, 64'h0));
		directed.push_back(row_request(CMD_PUSH, 32'h8000_0000, 1, 40'hFF_FFFF_FFFF, 64'h0));
		directed.push_back(row_request(CMD_PUSH, 32'hFFFF_FFFF, 1, 40'hFF_FFFF_FFFE, 64'h0));
		directed.push_back(row_request(CMD_CLEAR, 32'hDEAD_BEEF, 1, 40'h0, 64'h0));
		directed.push_back(row_request(CMD_PUSH, 32'h8000_0000, 1, 40'hFF_8000_0000, 64'h0));
		// A window of one sample replaces its only entry on every push.
		directed.push_back(row_write(REG_WINDOW_SIZE, 8'd1));
		directed.push_back(row_request(CMD_PUSH, 32'h0000_0005, 1, 40'h00_0000_0005, 64'h0));
		directed.push_back(row_request(CMD_PUSH, 32'hFFFF_FFFD, 1, 40'hFF_FFFF_FFFD, 64'h0));
		// A window size of zero acts as a window of one.
		directed.push_back(row_write(REG_WINDOW_SIZE, 8'd0));
		directed.push_back(row_request(CMD_PUSH, 32'h0000_0007, 1, 40'h00_0000_0007, 64'h0));
		directed.push_back(row_request(CMD_PUSH, 32'h0000_0009, 1, 40'h00_0000_0009, 64'h0));
		directed.push_back(row_write(REG_WINDOW_SIZE, 8'd2));
		directed.push_back(row_request(CMD_PUSH, 32'h0000_0001, 0, '0, '0));
		directed.push_back(row_request(CMD_PUSH, 32'h0000_0002, 0, '0, '0));
		directed.push_back(row_request(CMD_PUSH, 32'h0000_0003, 0, '0, '0));
		// Bit mode over a window of two: upper sample bits are ignored.
		directed.push_back(row_write(REG_COUNT_MODE, {7'd0, MODE_BITS}));
		directed.push_back(row_request(CMD_PUSH, 32'h0000_00FF, 1, 40'h0, 64'h0101_0101_0101_0101));
		directed.push_back(row_request(CMD_PUSH, 32'hFFFF_FF00, 1, 40'h0, 64'h0101_0101_0101_0101));
		directed.push_back(row_request(CMD_PUSH, 32'h0000_0055, 1, 40'h0, 64'h0001_0001_0001_0001));
		directed.push_back(row_request(CMD_CLEAR, 32'h0000_00FF, 1, 40'h0, 64'h0));
		directed.push_back(row_write(REG_WINDOW_SIZE, 8'd255));
		directed.push_back(row_request(CMD_PUSH, 32'h0000_00AA, 0, '0, '0));
		directed.push_back(row_request(CMD_PUSH, 32'h8000_0001, 0, '0, '0));
		// Only bit zero of the mode register counts.
		directed.push_back(row_write(REG_COUNT_MODE, {7'h7F, MODE_SUM}));
		directed.push_back(row_request(CMD_PUSH, 32'h0000_000A, 1, 40'h00_0000_000A, 64'h0));
		directed.push_back(row_request(CMD_PUSH, 32'h8000_0000, 0, '0, '0));
		directed.push_back(row_request(CMD_CLEAR, 32'h0, 1, 40'h0, 64'h0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_WRITE)
				write_register(directed[i].idx, directed[i].data);
			else
				send_request(directed[i].cmd, directed[i].smp, directed[i].typed,
					directed[i].want, 1'b0);
		end

		// Random phases. The first three fill a full window with extreme samples.
		done = 0;
		phase = 0;
		while (done < 1650) begin
			case (phase)
				0: begin
					size_pick = 8'd255;
					mode_pick = MODE_SUM;
					feed = FEED_TOP;
				end
				1: begin
					size_pick = 8'd255;
					mode_pick = MODE_SUM;
					feed = FEED_BOTTOM;
				end
				2: begin
					size_pick = 8'd255;
					mode_pick = MODE_BITS;
					feed = FEED_TOP;
				end
				default: begin
					r = $urandom_range(0, 9);
					if (r == 0)
						size_pick = 8'd0;
					else if (r == 1)
						size_pick = 8'd1;
					else if (r == 2)
						size_pick = 8'd255;
					else if (r == 3)
						size_pick = SIZE_W'($urandom_range(100, 254));
					else
						size_pick = SIZE_W'($urandom_range(2, 16));
					mode_pick = 1'($urandom_range(0, 1));
					feed = FEED_MIXED;
				end
			endcase
			pad = 7'($urandom_range(0, 127));
			if ($urandom_range(0, 1)) begin
				write_register(REG_WINDOW_SIZE, size_pick);
				write_register(REG_COUNT_MODE, {pad, mode_pick});
			end else begin
				write_register(REG_COUNT_MODE, {pad, mode_pick});
				write_register(REG_WINDOW_SIZE, size_pick);
			end

			items = (size_pick >= 100) ? size_pick + $urandom_range(10, 60) : $urandom_range(40, 120);
			steady = ($urandom_range(0, 3) == 0);
			repeat (items) begin
				cmd = (feed == FEED_MIXED && $urandom_range(0, 39) == 0) ? CMD_CLEAR : CMD_PUSH;
				case (feed)
					FEED_TOP:    smp = 32'h7FFF_FFFF;
					FEED_BOTTOM: smp = 32'h8000_0000;
					default: begin
						r = $urandom_range(0, 7);
						if (r == 0) begin
							case ($urandom_range(0, 3))
								0: smp = 32'h0000_0000;
								1: smp = 32'h7FFF_FFFF;
								2: smp = 32'h8000_0000;
								default: smp = 32'hFFFF_FFFF;
							endcase
						end else if (r == 1) begin
							smp = SAMPLE_W'($urandom_range(0, 15));
							if ($urandom_range(0, 1))
								smp = -smp;
						end else begin
							smp = $urandom;
						end
					end
				endcase
				send_request(cmd, smp, 1'b0, '0, steady);
			end
			done += items;
			phase++;
		end

		// Drain, then allow time for any stray result.
		await_idle();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("sliding_window_sum_and_bit_counts: match");
		else
			$display("sliding_window_sum_and_bit_counts: mismatch");
		$finish;
	end

	initial begin : watchdog
		#1_500_000;
		$display("sliding_window_sum_and_bit_counts: mismatch");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/swsb_pkg.sv
rtl/swsb_ring.sv
rtl/swsb_accum.sv
rtl/sliding_window_sum_and_bit_counts.sv
tb/tb_top.sv
